@@ hw/rtl/fbm_pkg.sv @@
// Shared types, constants and helpers for the frame bitmap allocator.
// No dependencies; every other file in this block uses it.
`timescale 1ns / 1ps
`default_nettype none

package fbm_pkg;

  localparam int DEF_BITMAP_WORDS = 4096;

  localparam int CFG_W    = 13;
  localparam int FRAME_W  = 17;
  localparam int STATUS_W = 3;
  localparam int WORD_W   = 32;
  localparam int BIT_W    = 5;

  localparam logic [CFG_W-1:0]  WORDS_IN_USE_RESET = 13'd4096;
  localparam logic [WORD_W-1:0] FULL_WORD          = 32'hFFFF_FFFF;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 3'd0,
    ST_MAPPED  = 3'd1,
    ST_FULL    = 3'd2,
    ST_NOFRAME = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_req;   // capture request payload
    logic    scan_start; // clear scan counter
    logic    scan_step;  // issue next scan read
    logic    free_rd;    // read the word named by the free request
    logic    cap;        // hold returned word and its address
    logic    wr;         // write back the updated word
    logic    set_res;    // load result registers
    status_t res_status;
    logic    out_load;   // move result into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op;
    logic pf_zero;
    logic pf_range;
    logic found;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

  // index of the lowest clear bit; only used on words that are not full
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!w[b]) begin
        idx = BIT_W'(b);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fbm_if.sv @@
// Request and response channel interfaces (valid/ready plus payload).
// Depends on fbm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fbm_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [fbm_pkg::FRAME_W-1:0]   page_frame;
  logic                          kernel_page;
  logic                          writable;

  modport source (output valid, output op, output page_frame, output kernel_page,
                  output writable, input ready);
  modport sink   (input valid, input op, input page_frame, input kernel_page,
                  input writable, output ready);
endinterface

interface fbm_resp_if;
  logic                          valid;
  logic                          ready;
  logic [fbm_pkg::STATUS_W-1:0]  status;
  logic [fbm_pkg::FRAME_W-1:0]   frame_out;
  logic                          present_out;
  logic                          rw_out;
  logic                          user_out;

  modport source (output valid, output status, output frame_out, output present_out,
                  output rw_out, output user_out, input ready);
  modport sink   (input valid, input status, input frame_out, input present_out,
                  input rw_out, input user_out, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fbm_datapath.sv @@
// Bitmap memory, scan counter, request/result registers and output stage.
// Depends on fbm_pkg; driven by fbm_ctrl through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module fbm_datapath #(
  parameter int BITMAP_WORDS = fbm_pkg::DEF_BITMAP_WORDS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fbm_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          op,
  input  wire logic [fbm_pkg::FRAME_W-1:0]   page_frame,
  input  wire logic                          kernel_page,
  input  wire logic                          writable,
  input  wire fbm_pkg::dp_cmd_t              cmd,
  output fbm_pkg::dp_sts_t                   sts,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [fbm_pkg::STATUS_W-1:0]       status,
  output logic [fbm_pkg::FRAME_W-1:0]        frame_out,
  output logic                               present_out,
  output logic                               rw_out,
  output logic                               user_out
);

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int CW = $clog2(BITMAP_WORDS + 1);
  localparam int NW = (CW > fbm_pkg::CFG_W) ? CW : fbm_pkg::CFG_W;
  localparam logic [NW-1:0] BW_N = NW'(BITMAP_WORDS);

  localparam int FW = fbm_pkg::FRAME_W;
  localparam int WW = fbm_pkg::WORD_W;
  localparam int BW = fbm_pkg::BIT_W;

  // configuration
  logic [fbm_pkg::CFG_W-1:0] words_in_use;
  logic [NW-1:0]             wiu_n;
  logic [NW-1:0]             nw;

  // request
  logic          op_q;
  logic [FW-1:0] pf_q;
  logic          kern_q;
  logic          wr_q;
  logic [NW-1:0] pf_word_n;

  // bitmap and scan
  logic [WW-1:0] mem [BITMAP_WORDS];
  logic [WW-1:0] mem_q;
  logic [AW-1:0] addr_q;
  logic          q_valid;
  logic [NW-1:0] cnt;
  logic          cnt_live;
  logic [CW-1:0] hwm;       // words at or above this were never written: read as zero
  logic [WW-1:0] eff_word;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic [WW-1:0] hold_word;
  logic [AW-1:0] hold_addr;
  logic [NW-1:0] hold_addr_n;
  logic [BW-1:0] zbit;
  logic [NW+BW-1:0] alloc_frame_w;
  logic          hold_in_use;
  logic          mem_we;
  logic [WW-1:0] mem_wdata;

  // result
  fbm_pkg::status_t res_status;
  logic [FW-1:0]    res_frame;
  logic             res_present;
  logic             res_rw;
  logic             res_user;

  assign wiu_n     = NW'(words_in_use);
  assign nw        = (wiu_n > BW_N) ? BW_N : wiu_n;
  assign pf_word_n = NW'(pf_q[FW-1:BW]);
  assign cnt_live  = cnt < nw;

  assign rd_en   = cmd.free_rd || (cmd.scan_step && cnt_live);
  assign rd_addr = cmd.free_rd ? pf_word_n[AW-1:0] : cnt[AW-1:0];

  assign eff_word = (CW'(addr_q) < hwm) ? mem_q : '0;

  assign hold_addr_n   = NW'(hold_addr);
  assign zbit          = fbm_pkg::lowest_zero(hold_word);
  assign alloc_frame_w = {hold_addr_n, zbit};
  assign hold_in_use   = CW'(hold_addr) < hwm;

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = hold_word;
    if (cmd.wr) begin
      if (op_q == fbm_pkg::OP_ALLOC) begin
        mem_we    = 1'b1;
        mem_wdata = hold_word | (WW'(1) << zbit);
      end else begin
        // untouched words are zero already; nothing to clear
        mem_we    = hold_in_use;
        mem_wdata = hold_word & ~(WW'(1) << pf_q[BW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= fbm_pkg::WORDS_IN_USE_RESET;
    end else if (cfg_we) begin
      words_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_q   <= op;
      pf_q   <= page_frame;
      kern_q <= kernel_page;
      wr_q   <= writable;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[hold_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q  <= mem[rd_addr];
      addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      q_valid <= 1'b0;
      hwm     <= '0;
    end else begin
      q_valid <= cmd.scan_step && cnt_live;
      if (cmd.scan_start) begin
        cnt <= '0;
      end else if (cmd.scan_step && cnt_live) begin
        cnt <= cnt + NW'(1);
      end
      // an allocation only ever lands on the first word not yet written
      if (cmd.wr && op_q == fbm_pkg::OP_ALLOC && !hold_in_use) begin
        hwm <= CW'(hold_addr) + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      hold_word <= eff_word;
      hold_addr <= addr_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status  <= cmd.res_status;
      res_frame   <= '0;
      res_present <= 1'b0;
      res_rw      <= 1'b0;
      res_user    <= 1'b0;
      case (cmd.res_status)
        fbm_pkg::ST_DONE: begin
          if (op_q == fbm_pkg::OP_ALLOC) begin
            res_frame   <= alloc_frame_w[FW-1:0];
            res_present <= 1'b1;
            res_rw      <= wr_q;
            res_user    <= ~kern_q;
          end else begin
            res_frame <= pf_q;
          end
        end
        fbm_pkg::ST_MAPPED, fbm_pkg::ST_RANGE: begin
          res_frame <= pf_q;
        end
        default: begin
          res_frame <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= res_status;
      frame_out   <= res_frame;
      present_out <= res_present;
      rw_out      <= res_rw;
      user_out    <= res_user;
    end
  end

  assign sts.op        = op_q;
  assign sts.pf_zero   = (pf_q == '0);
  assign sts.pf_range  = (pf_word_n >= nw);
  assign sts.found     = q_valid && (eff_word != fbm_pkg::FULL_WORD);
  assign sts.scan_done = !cnt_live && !q_valid;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ hw/rtl/fbm_ctrl.sv @@
// Request sequencer: decode, first-fit scan, read-modify-write, result hand-off.
// Depends on fbm_pkg; commands fbm_datapath.
`timescale 1ns / 1ps
`default_nettype none

module fbm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire fbm_pkg::dp_sts_t sts,
  output fbm_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FREE_WAIT,
    S_WRITE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.res_status = fbm_pkg::ST_DONE;
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op == fbm_pkg::OP_ALLOC) begin
          if (!sts.pf_zero) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = fbm_pkg::ST_MAPPED;
            state_next     = S_EMIT;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end else if (sts.pf_zero) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = fbm_pkg::ST_NOFRAME;
          state_next     = S_EMIT;
        end else if (sts.pf_range) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = fbm_pkg::ST_RANGE;
          state_next     = S_EMIT;
        end else begin
          cmd.free_rd = 1'b1;
          state_next  = S_FREE_WAIT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.found) begin
          cmd.cap    = 1'b1;
          state_next = S_WRITE;
        end else if (sts.scan_done) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = fbm_pkg::ST_FULL;
          state_next     = S_EMIT;
        end
      end
      S_FREE_WAIT: begin
        cmd.cap    = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr         = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = fbm_pkg::ST_DONE;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/frame_bitmap_allocator.sv @@
// First-fit physical frame allocator over a bitmap of 32-frame words.
// Skipped allocs and errors go DECODE then EMIT; a free goes DECODE, FREE_WAIT, WRITE, EMIT;
//   a scanning alloc reads words up to the first non-full one, then goes to WRITE and EMIT;
//   a full bitmap reads every managed word. The scan reads one word per cycle.
// Throughput: one request at a time; the next is taken once the result is in the output reg.
// Reset (rst, synchronous): bitmap reads as all free via a written-words mark, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module frame_bitmap_allocator #(
  parameter int BITMAP_WORDS = fbm_pkg::DEF_BITMAP_WORDS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration: words_in_use
  input  wire logic                      cfg_we,
  input  wire logic [fbm_pkg::CFG_W-1:0] cfg_wdata,
  // request channel
  fbm_req_if.sink                        req,
  // result channel
  fbm_resp_if.source                     resp
);

  fbm_pkg::dp_cmd_t cmd;
  fbm_pkg::dp_sts_t sts;
  logic             ctl_ready;

  // Controller: one request in flight. IDLE takes a request, DECODE
  // sorts out skipped / error cases, SCAN walks the bitmap one word per
  // cycle (reads are pipelined; a speculative read past the hit is dropped),
  // WRITE does the read-modify-write, EMIT waits for the output register.
  fbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ctl_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  assign req.ready = ctl_ready;

  // Datapath: bitmap memory with a registered read port, the written-words
  // mark that stands in for clearing, the scan counter, and the output stage.
  fbm_datapath #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .op          (req.op),
    .page_frame  (req.page_frame),
    .kernel_page (req.kernel_page),
    .writable    (req.writable),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (resp.ready),
    .out_valid   (resp.valid),
    .status      (resp.status),
    .frame_out   (resp.frame_out),
    .present_out (resp.present_out),
    .rw_out      (resp.rw_out),
    .user_out    (resp.user_out)
  );

endmodule

`default_nettype wire

@@ hw/rtl/fbm_checker.sv @@
// Port-level assertions for the frame bitmap allocator, bound to the top level.
// Depends on fbm_pkg and frame_bitmap_allocator.
`timescale 1ns / 1ps
`default_nettype none

module fbm_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         req_valid,
  input wire logic                         req_ready,
  input wire logic                         resp_valid,
  input wire logic                         resp_ready,
  input wire logic [fbm_pkg::STATUS_W-1:0] resp_status,
  input wire logic [fbm_pkg::FRAME_W-1:0]  resp_frame,
  input wire logic                         resp_present
);

  // one request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one in flight");

  // DECODE lies between accept and any result: no result rises the cycle after accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(resp_valid))
    else $error("result appeared one cycle after request accept");

  // only a successful result may carry a present bit
  a_present_only_done: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp_present |-> resp_status == fbm_pkg::ST_DONE)
    else $error("present bit set on a non-done result");

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid)
    else $error("result dropped while stalled");

  a_resp_stable: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> $stable(resp_status) && $stable(resp_frame))
    else $error("result payload changed while stalled");

endmodule

bind frame_bitmap_allocator fbm_checker u_fbm_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .resp_valid   (resp.valid),
  .resp_ready   (resp.ready),
  .resp_status  (resp.status),
  .resp_frame   (resp.frame_out),
  .resp_present (resp.present_out)
);

`default_nettype wire

@@ tb/sv/tb_frame_bitmap_allocator.sv @@
// Self-checking testbench for frame_bitmap_allocator: directed and random alloc/free requests
// against an in-bench bitmap predictor, with random request gaps and result-side back-pressure.
// Depends on fbm_pkg and the fbm_req_if / fbm_resp_if interfaces from the RTL.
`timescale 1ns / 1ps

module tb_frame_bitmap_allocator;

  localparam int MAP_WORDS   = fbm_pkg::DEF_BITMAP_WORDS;
  localparam int FRAME_MAX   = (1 << fbm_pkg::FRAME_W) - 1;
  localparam int SETTLE_CYC  = 8;     // pause before a register write
  localparam int TAIL_CYC    = 16;    // quiet time after the last result
  // worst correct quiet stretch: a full-map scan plus the longest gap and stall, several times over
  localparam int QUIET_LIMIT = 6 * (MAP_WORDS + 64);

  // one page-entry result as the block reports it
  typedef struct packed {
    fbm_pkg::status_t                status;
    logic [fbm_pkg::FRAME_W-1:0]     frame;
    logic                            present;
    logic                            rw;
    logic                            user;
  } entry_result_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [fbm_pkg::CFG_W-1:0]     cfg_wdata;

  fbm_req_if  req_ch ();
  fbm_resp_if resp_ch ();

  frame_bitmap_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .resp      (resp_ch)
  );

  // predictor state: our own copy of the bitmap and the words_in_use register
  logic [fbm_pkg::WORD_W-1:0]    frame_map [MAP_WORDS];
  logic [fbm_pkg::CFG_W-1:0]     words_model;

  entry_result_t                 pending_results [$];   // expected results, oldest first
  logic [fbm_pkg::FRAME_W-1:0]   held_frames [$];       // frames handed out and not yet freed
  int                            mismatch_count;
  int                            quiet_cycles;
  int                            stall_left;
  bit                            gaps_on;
  bit                            stalls_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_idle_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // words actually scanned/freed: register saturates at the bitmap size
  function automatic int managed_words();
    return (int'(words_model) > MAP_WORDS) ? MAP_WORDS : int'(words_model);
  endfunction

  // First-fit predictor. Alloc with a nonzero entry is skipped; otherwise the lowest
  // clear bit over the managed words is taken. Free clears the bit of an in-range frame.
  function automatic entry_result_t predict_entry(input logic op,
                                                  input logic [fbm_pkg::FRAME_W-1:0] pf,
                                                  input logic kern, input logic wr);
    entry_result_t r;
    int            nw;
    bit            found;
    r     = '0;
    nw    = managed_words();
    found = 1'b0;
    if (op == fbm_pkg::OP_ALLOC) begin
      if (pf != '0) begin
        r.status = fbm_pkg::ST_MAPPED;
        r.frame  = pf;
      end else begin
        for (int w = 0; w < nw && !found; w++) begin
          if (frame_map[w] != fbm_pkg::FULL_WORD) begin
            for (int b = 0; b < fbm_pkg::WORD_W && !found; b++) begin
              if (!frame_map[w][b]) begin
                frame_map[w][b] = 1'b1;
                r.status  = fbm_pkg::ST_DONE;
                r.frame   = fbm_pkg::FRAME_W'(w * fbm_pkg::WORD_W + b);
                r.present = 1'b1;
                r.rw      = wr;
                r.user    = ~kern;
                found     = 1'b1;
              end
            end
          end
        end
        if (!found) r.status = fbm_pkg::ST_FULL;
      end
    end else if (pf == '0) begin
      r.status = fbm_pkg::ST_NOFRAME;
    end else if (int'(pf >> fbm_pkg::BIT_W) >= nw) begin
      r.status = fbm_pkg::ST_RANGE;
      r.frame  = pf;
    end else begin
      // freeing an already free frame is legal and still reports done
      frame_map[pf >> fbm_pkg::BIT_W][pf[fbm_pkg::BIT_W-1:0]] = 1'b0;
      r.status = fbm_pkg::ST_DONE;
      r.frame  = pf;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Drive one request: optional gap, then hold valid until the handshake.
  // valid gets exactly one update per falling edge so back-to-back requests stay high.
  task automatic send_frame_op(input logic op, input logic [fbm_pkg::FRAME_W-1:0] pf,
                               input logic kern, input logic wr);
    int            gap;
    entry_result_t want;
    gap = gaps_on ? pick_idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.page_frame  <= pf;
    req_ch.kernel_page <= kern;
    req_ch.writable    <= wr;
    do @(posedge clk); while (!req_ch.ready);
    // request accepted at this edge: predict and queue its result
    want = predict_entry(op, pf, kern, wr);
    pending_results.push_back(want);
    if (op == fbm_pkg::OP_ALLOC && want.status == fbm_pkg::ST_DONE)
      held_frames.push_back(want.frame);
  endtask

  // Register writes only while idle: drop valid, drain results, settle, then write.
  task automatic write_words_in_use(input logic [fbm_pkg::CFG_W-1:0] value);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    words_model = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic. Mostly well-formed: allocs of empty entries and frees of held
  // frames. The rest is noise: mapped entries, free of nothing, stray or out-of-range frames.
  task automatic run_random_ops(input int count, input int alloc_pct);
    int                          roll;
    int                          idx;
    int                          span;
    logic [fbm_pkg::FRAME_W-1:0] pf;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      span = managed_words();
      if (roll < alloc_pct) begin
        send_frame_op(fbm_pkg::OP_ALLOC, '0, 1'($urandom), 1'($urandom));
      end else if (roll < alloc_pct + 6) begin
        pf = fbm_pkg::FRAME_W'($urandom_range(1, FRAME_MAX));
        send_frame_op(fbm_pkg::OP_ALLOC, pf, 1'($urandom), 1'($urandom));
      end else if (held_frames.size() != 0 && roll < 92) begin
        idx = $urandom_range(held_frames.size() - 1);
        pf  = held_frames[idx];
        held_frames.delete(idx);
        send_frame_op(fbm_pkg::OP_FREE, pf, 1'($urandom), 1'($urandom));
      end else begin
        case ($urandom_range(2))
          0: pf = '0;
          1: pf = fbm_pkg::FRAME_W'($urandom);
          default: begin
            if (span < MAP_WORDS)
              pf = fbm_pkg::FRAME_W'($urandom_range(span * fbm_pkg::WORD_W, FRAME_MAX));
            else pf = fbm_pkg::FRAME_W'($urandom);
          end
        endcase
        send_frame_op(fbm_pkg::OP_FREE, pf, 1'($urandom), 1'($urandom));
      end
    end
  endtask

  // After reset: frame 0 is handed out first, flag combinations, skipped allocs,
  // free of nothing, free of a free frame in the top word, reuse of a freed frame.
  task automatic test_reset_state();
    send_frame_op(fbm_pkg::OP_ALLOC, '0, 1'b0, 1'b0);
    send_frame_op(fbm_pkg::OP_ALLOC, '0, 1'b1, 1'b1);
    send_frame_op(fbm_pkg::OP_ALLOC, '0, 1'b0, 1'b1);
    send_frame_op(fbm_pkg::OP_ALLOC, '0, 1'b1, 1'b0);
    send_frame_op(fbm_pkg::OP_ALLOC, fbm_pkg::FRAME_W'(FRAME_MAX), 1'b1, 1'b1);
    send_frame_op(fbm_pkg::OP_ALLOC, fbm_pkg::FRAME_W'(1), 1'b0, 1'b0);
    send_frame_op(fbm_pkg::OP_FREE, '0, 1'b1, 1'b1);
    send_frame_op(fbm_pkg::OP_FREE, fbm_pkg::FRAME_W'(1), 1'b0, 1'b0);
    send_frame_op(fbm_pkg::OP_ALLOC, '0, 1'b0, 1'b1);
    send_frame_op(fbm_pkg::OP_FREE, fbm_pkg::FRAME_W'(FRAME_MAX), 1'b1, 1'b0);
    send_frame_op(fbm_pkg::OP_FREE, fbm_pkg::FRAME_W'(5), 1'b0, 1'b1);
  endtask

  // Register extremes: zero words manages nothing, 8191 saturates, one word bounds frees.
  task automatic test_register_extremes();
    write_words_in_use(fbm_pkg::CFG_W'(0));
    send_frame_op(fbm_pkg::OP_ALLOC, '0, 1'b0, 1'b1);
    send_frame_op(fbm_pkg::OP_FREE, fbm_pkg::FRAME_W'(1), 1'b0, 1'b0);
    send_frame_op(fbm_pkg::OP_FREE, '0, 1'b0, 1'b0);
    send_frame_op(fbm_pkg::OP_FREE, fbm_pkg::FRAME_W'(FRAME_MAX), 1'b1, 1'b1);
    write_words_in_use(fbm_pkg::CFG_W'((1 << fbm_pkg::CFG_W) - 1));
    send_frame_op(fbm_pkg::OP_ALLOC, '0, 1'b1, 1'b1);
    send_frame_op(fbm_pkg::OP_FREE, fbm_pkg::FRAME_W'(FRAME_MAX), 1'b0, 1'b0);
    write_words_in_use(fbm_pkg::CFG_W'(1));
    send_frame_op(fbm_pkg::OP_FREE, fbm_pkg::FRAME_W'(fbm_pkg::WORD_W), 1'b0, 1'b0);
    send_frame_op(fbm_pkg::OP_FREE, fbm_pkg::FRAME_W'(fbm_pkg::WORD_W - 1), 1'b0, 1'b0);
  endtask

  // One word, alloc-heavy: fills the word, hits the full-map case, then recovers via frees.
  task automatic test_fill_single_word();
    write_words_in_use(fbm_pkg::CFG_W'(1));
    run_random_ops(45, 85);
  endtask

  task automatic test_small_map();
    write_words_in_use(fbm_pkg::CFG_W'($urandom_range(2, 3)));
    run_random_ops(25, 60);
  endtask

  // Full register range with word 0 likely full: the scan must pass over it.
  // Run back-to-back with no gaps or stalls.
  task automatic test_full_map_burst();
    write_words_in_use(fbm_pkg::WORDS_IN_USE_RESET);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_random_ops(25, 55);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Shrink back to one word: bits above it are kept but out of range until regrown.
  task automatic test_shrink_and_regrow();
    write_words_in_use(fbm_pkg::CFG_W'(1));
    run_random_ops(15, 40);
    write_words_in_use(fbm_pkg::CFG_W'((1 << fbm_pkg::CFG_W) - 1));
    run_random_ops(15, 50);
  endtask

  // Result side: random back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      resp_ch.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stalls_on && $urandom_range(99) < 25) begin
      resp_ch.ready <= 1'b0;
      stall_left    <= pick_idle_len();
    end else begin
      resp_ch.ready <= 1'b1;
    end
  end

  task automatic check_entry();
    entry_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with none expected: status=%0d frame=%0d",
                                resp_ch.status, resp_ch.frame_out));
      return;
    end
    want = pending_results.pop_front();
    if (resp_ch.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", resp_ch.status, want.status));
    if (resp_ch.frame_out !== want.frame)
      report_mismatch($sformatf("frame %0d, want %0d", resp_ch.frame_out, want.frame));
    if (resp_ch.present_out !== want.present)
      report_mismatch($sformatf("present %0b, want %0b", resp_ch.present_out, want.present));
    if (resp_ch.rw_out !== want.rw)
      report_mismatch($sformatf("rw %0b, want %0b", resp_ch.rw_out, want.rw));
    if (resp_ch.user_out !== want.user)
      report_mismatch($sformatf("user %0b, want %0b", resp_ch.user_out, want.user));
  endtask

  // Checker and watchdog: sample on the rising edge, count edges with no handshake.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (resp_ch.valid && resp_ch.ready) check_entry();
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.op           = fbm_pkg::OP_ALLOC;
    req_ch.page_frame   = '0;
    req_ch.kernel_page  = 1'b0;
    req_ch.writable     = 1'b0;
    resp_ch.ready       = 1'b0;
    stall_left          = 0;
    mismatch_count      = 0;
    gaps_on             = 1'b1;
    stalls_on           = 1'b1;
    words_model         = fbm_pkg::WORDS_IN_USE_RESET;
    foreach (frame_map[i]) frame_map[i] = '0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_register_extremes();
    test_fill_single_word();
    test_small_map();
    test_full_map_burst();
    test_shrink_and_regrow();

    // drain: every queued result must arrive, then a short quiet tail
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
